// ===== design/lsrp_pkg.sv =====
package lsrp_pkg;

    localparam int PHASE_BITS = 30;
    localparam int UNIT_FRAC  = 16;
    localparam int TAB_LEN    = 24;
    localparam int CW         = 34;

    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [28:0] INV_PI_Q30  = 29'd341782638;

    localparam logic signed [CW-1:0] GAIN_Q30   = 34'sd652032874;
    localparam logic signed [CW-1:0] Q30_ONE_S  = 34'sd1073741824;
    localparam logic signed [CW-1:0] Q31_TWO_S  = 34'sd2147483648;

    localparam logic [29:0] ATAN_TAB [0:TAB_LEN-1] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
        30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
        30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
        30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
    };

    typedef enum logic [2:0] {
        REG_START_X        = 3'd0,
        REG_START_Y        = 3'd1,
        REG_HEADING_ANGLE  = 3'd2,
        REG_HEADING_COSINE = 3'd3,
        REG_HEADING_SINE   = 3'd4,
        REG_PATH_LENGTH    = 3'd5,
        REG_TOP_SPEED      = 3'd6,
        REG_RAMP_TIME      = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [31:0]           t;
        logic                  ramping;
        logic [PHASE_BITS-1:0] p;
    } side_t;

    typedef struct packed {
        logic [31:0] t;
        logic        ramping;
        logic [30:0] speed;
        logic        reached;
    } kin_t;

endpackage

// ===== design/lsrp_divider.sv =====
module lsrp_divider
    import lsrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] in_t,
    input  logic [31:0] ramp_time,
    output logic        out_valid,
    output side_t       out_side
);

    logic                  v_reg   [0:PHASE_BITS];
    logic [31:0]           t_reg   [0:PHASE_BITS];
    logic                  rmp_reg [0:PHASE_BITS];
    logic [31:0]           rem_reg [0:PHASE_BITS];
    logic [PHASE_BITS-1:0] q_reg   [0:PHASE_BITS];

    // capture stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0]   <= in_t;
            rmp_reg[0] <= (in_t < ramp_time);
            rem_reg[0] <= in_t;
            q_reg[0]   <= '0;
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= PHASE_BITS; k++)
    begin : g_div
        logic [32:0] shifted;
        logic [32:0] diff;
        logic        take;
        logic [31:0] rem_next;

        always_comb
        begin
            shifted  = {rem_reg[k-1], 1'b0};
            diff     = shifted - {1'b0, ramp_time};
            take     = (shifted >= {1'b0, ramp_time});
            rem_next = take ? diff[31:0] : shifted[31:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                t_reg[k]   <= t_reg[k-1];
                rmp_reg[k] <= rmp_reg[k-1];
                rem_reg[k] <= rem_next;
                q_reg[k]   <= {q_reg[k-1][PHASE_BITS-2:0], take};
            end
        end
    end

    assign out_valid        = v_reg[PHASE_BITS];
    assign out_side.t       = t_reg[PHASE_BITS];
    assign out_side.ramping = rmp_reg[PHASE_BITS];
    assign out_side.p       = q_reg[PHASE_BITS];

endmodule

// ===== design/lsrp_cordic.sv =====
module lsrp_cordic
    import lsrp_pkg::*;
#(
    parameter int STAGES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  side_t                in_side,
    output logic                 out_valid,
    output side_t                out_side,
    output logic signed [CW-1:0] cos_q,
    output logic signed [CW-1:0] sin_q
);

    logic                 v_reg [0:STAGES];
    side_t                s_reg [0:STAGES];
    logic signed [CW-1:0] x_reg [0:STAGES];
    logic signed [CW-1:0] y_reg [0:STAGES];
    logic signed [CW-1:0] z_reg [0:STAGES];

    logic [61:0]          ang_prod;
    logic signed [CW-1:0] z_next;

    // phase to angle, shifted by a quarter turn
    always_comb
    begin
        ang_prod = 62'(in_side.p) * 62'(PI_Q30);
        z_next   = $signed({2'b00, ang_prod[61:30]}) - $signed({2'b00, HALF_PI_Q30});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg[0] <= in_side;
            x_reg[0] <= GAIN_Q30;
            y_reg[0] <= '0;
            z_reg[0] <= z_next;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_rot
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] at;

        always_comb
        begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            at = $signed({{(CW-30){1'b0}}, ATAN_TAB[i]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[i+1] <= s_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - at;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + at;
                end
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign out_side  = s_reg[STAGES];
    assign cos_q     = x_reg[STAGES];
    assign sin_q     = y_reg[STAGES];

endmodule

// ===== design/lsrp_kin.sv =====
module lsrp_kin
    import lsrp_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  side_t                in_side,
    input  logic signed [CW-1:0] cz,
    input  logic signed [CW-1:0] sz,
    input  logic [30:0]          top_speed,
    input  logic [31:0]          ramp_time,
    input  logic [30:0]          path_length,
    output logic                 out_valid,
    output kin_t                 out_kin,
    output logic [30:0]          out_dist
);

    // stage b: clamps
    logic                  vb_reg;
    side_t                 sb_reg;
    logic [31:0]           omc_reg;
    logic [30:0]           sp_reg;
    logic [31:0]           tdiff_reg;
    logic signed [CW-1:0]  omc_s;
    logic [31:0]           omc_next;
    logic [30:0]           sp_next;

    always_comb
    begin
        omc_s = sz + Q30_ONE_S;
        if (omc_s < 0)
        begin
            omc_next = '0;
        end
        else if (omc_s > Q31_TWO_S)
        begin
            omc_next = Q31_TWO_S[31:0];
        end
        else
        begin
            omc_next = omc_s[31:0];
        end
        if (cz < 0)
        begin
            sp_next = '0;
        end
        else if (cz > Q30_ONE_S)
        begin
            sp_next = Q30_ONE_S[30:0];
        end
        else
        begin
            sp_next = cz[30:0];
        end
    end

    // stage c: products
    logic        vc_reg;
    side_t       sc_reg;
    logic [62:0] smul_reg;
    logic [59:0] spm_reg;
    logic [62:0] cm1_reg;
    logic [62:0] cm2_reg;

    // stage d: speed, q, cruise distance
    logic        vd_reg;
    side_t       sd_reg;
    logic [30:0] spd_reg;
    logic [29:0] q_reg;
    logic [63:0] cd_reg;
    logic [63:0] ssum;
    logic [31:0] spd_raw;
    logic [30:0] spd_next;
    logic [29:0] qsub;
    logic [29:0] q_next;
    logic [63:0] cd_next;

    always_comb
    begin
        ssum    = 64'(smul_reg) + 64'(Q30_ONE_S[30:0]);
        spd_raw = ssum[62:31];
        spd_next = (spd_raw > 32'(top_speed)) ? top_speed : spd_raw[30:0];
        qsub    = spm_reg[59:30];
        q_next  = (sc_reg.p >= qsub) ? (sc_reg.p - qsub) : '0;
        cd_next = 64'(cm1_reg >> (FRAC_BITS + 1)) + 64'(cm2_reg >> FRAC_BITS);
    end

    // stage e
    logic        ve_reg;
    side_t       se_reg;
    logic [30:0] spe_reg;
    logic [63:0] cde_reg;
    logic [60:0] vq_reg;

    // stage f
    logic        vf_reg;
    side_t       sf_reg;
    logic [30:0] spf_reg;
    logic [63:0] cdf_reg;
    logic [62:0] d_reg;

    // stage g: select and clamp
    logic        vg_reg;
    kin_t        kg_reg;
    logic [30:0] dist_reg;
    logic [63:0] dist_all;
    kin_t        kg_next;
    logic [30:0] dist_next;

    always_comb
    begin
        dist_all        = sf_reg.ramping ? 64'(d_reg >> (FRAC_BITS + 1)) : cdf_reg;
        kg_next.t       = sf_reg.t;
        kg_next.ramping = sf_reg.ramping;
        if (dist_all > 64'(path_length))
        begin
            dist_next       = path_length;
            kg_next.speed   = '0;
            kg_next.reached = 1'b1;
        end
        else
        begin
            dist_next       = dist_all[30:0];
            kg_next.speed   = sf_reg.ramping ? spf_reg : top_speed;
            kg_next.reached = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
        end
        else if (en)
        begin
            vb_reg <= in_valid;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
            vg_reg <= vf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg    <= in_side;
            omc_reg   <= omc_next;
            sp_reg    <= sp_next;
            tdiff_reg <= in_side.t - ramp_time;

            sc_reg   <= sb_reg;
            smul_reg <= 63'(top_speed) * 63'(omc_reg);
            spm_reg  <= 60'(sp_reg) * 60'(INV_PI_Q30);
            cm1_reg  <= 63'(top_speed) * 63'(ramp_time);
            cm2_reg  <= 63'(top_speed) * 63'(tdiff_reg);

            sd_reg  <= sc_reg;
            spd_reg <= spd_next;
            q_reg   <= q_next;
            cd_reg  <= cd_next;

            se_reg  <= sd_reg;
            spe_reg <= spd_reg;
            cde_reg <= cd_reg;
            vq_reg  <= 61'(top_speed) * 61'(q_reg);

            sf_reg  <= se_reg;
            spf_reg <= spe_reg;
            cdf_reg <= cde_reg;
            d_reg   <= 63'(vq_reg[60:30]) * 63'(ramp_time);

            kg_reg   <= kg_next;
            dist_reg <= dist_next;
        end
    end

    assign out_valid = vg_reg;
    assign out_kin   = kg_reg;
    assign out_dist  = dist_reg;

endmodule

// ===== design/lsrp_place.sv =====
module lsrp_place
    import lsrp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  kin_t               in_kin,
    input  logic [30:0]        in_dist,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [17:0] heading_cosine,
    input  logic signed [17:0] heading_sine,
    output logic               out_valid,
    output kin_t               out_kin,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y
);

    logic               vh_reg;
    kin_t               kh_reg;
    logic signed [49:0] mx_reg;
    logic signed [49:0] my_reg;
    logic signed [31:0] dist_s;
    logic signed [49:0] mx_next;
    logic signed [49:0] my_next;

    logic               vi_reg;
    kin_t               ki_reg;
    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic signed [49:0] sx;
    logic signed [49:0] sy;
    logic signed [31:0] px_next;
    logic signed [31:0] py_next;

    always_comb
    begin
        dist_s  = $signed({1'b0, in_dist});
        mx_next = dist_s * heading_cosine;
        my_next = dist_s * heading_sine;
    end

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -50'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    always_comb
    begin
        sx      = 50'(start_x) + (mx_reg >>> UNIT_FRAC);
        sy      = 50'(start_y) + (my_reg >>> UNIT_FRAC);
        px_next = sat32(sx);
        py_next = sat32(sy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vh_reg <= 1'b0;
            vi_reg <= 1'b0;
        end
        else if (en)
        begin
            vh_reg <= in_valid;
            vi_reg <= vh_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kh_reg <= in_kin;
            mx_reg <= mx_next;
            my_reg <= my_next;
            ki_reg <= kh_reg;
            px_reg <= px_next;
            py_reg <= py_next;
        end
    end

    assign out_valid = vi_reg;
    assign out_kin   = ki_reg;
    assign pos_x     = px_reg;
    assign pos_y     = py_reg;

endmodule

// ===== design/line_sine_ramp_profile.sv =====
// reference point generator on a straight line with a sinusoidal speed ramp
// input channel: in_valid / in_stall with sample_time (Q16.16 seconds)
// output channel: out_valid / out_stall with position, heading, speed,
// time stamp and the reached_end / ramping flags, one result per transaction
// configuration: cfg_write, cfg_index, cfg_data; write only while idle
// latency: 40 + TRIG_STAGES cycles from input transaction to result
// (31 phase-divider stages, the angle stage, the cordic rotation stages,
// six speed and distance stages, two position stages)
// throughput: one transaction per cycle, fully pipelined
// when the receiver stalls a held result, the whole pipeline freezes and
// in_stall rises; nothing is lost or repeated
// reset clears all valid bits and loads the register defaults
// (unit cosine, top speed and ramp time of one)
module line_sine_ramp_profile
    import lsrp_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int TRIG_STAGES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        sample_time,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [18:0] heading_out,
    output logic [30:0]        speed_out,
    output logic [31:0]        time_stamp,
    output logic               reached_end,
    output logic               ramping
);

    logic signed [31:0] start_x_reg;
    logic signed [31:0] start_y_reg;
    logic signed [18:0] heading_angle_reg;
    logic signed [17:0] heading_cosine_reg;
    logic signed [17:0] heading_sine_reg;
    logic [30:0]        path_length_reg;
    logic [30:0]        top_speed_reg;
    logic [31:0]        ramp_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg        <= '0;
            start_y_reg        <= '0;
            heading_angle_reg  <= '0;
            heading_cosine_reg <= 18'sd65536;
            heading_sine_reg   <= '0;
            path_length_reg    <= '0;
            top_speed_reg      <= 31'd65536;
            ramp_time_reg      <= 32'd65536;
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(cfg_index))
                REG_START_X:        start_x_reg        <= cfg_data;
                REG_START_Y:        start_y_reg        <= cfg_data;
                REG_HEADING_ANGLE:  heading_angle_reg  <= cfg_data[18:0];
                REG_HEADING_COSINE: heading_cosine_reg <= cfg_data[17:0];
                REG_HEADING_SINE:   heading_sine_reg   <= cfg_data[17:0];
                REG_PATH_LENGTH:    path_length_reg    <= cfg_data[30:0];
                REG_TOP_SPEED:      top_speed_reg      <= cfg_data[30:0];
                REG_RAMP_TIME:      ramp_time_reg      <= cfg_data;
                default:            ;
            endcase
        end
    end

    logic en;

    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    logic                 div_valid;
    side_t                div_side;
    logic                 cor_valid;
    side_t                cor_side;
    logic signed [CW-1:0] cor_cos;
    logic signed [CW-1:0] cor_sin;
    logic                 kin_valid;
    kin_t                 kin_res;
    logic [30:0]          kin_dist;
    kin_t                 out_kin;

    lsrp_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_t      (sample_time),
        .ramp_time (ramp_time_reg),
        .out_valid (div_valid),
        .out_side  (div_side)
    );

    lsrp_cordic #(
        .STAGES (TRIG_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_side   (div_side),
        .out_valid (cor_valid),
        .out_side  (cor_side),
        .cos_q     (cor_cos),
        .sin_q     (cor_sin)
    );

    lsrp_kin #(
        .FRAC_BITS (FRAC_BITS)
    ) u_kin (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (cor_valid),
        .in_side     (cor_side),
        .cz          (cor_cos),
        .sz          (cor_sin),
        .top_speed   (top_speed_reg),
        .ramp_time   (ramp_time_reg),
        .path_length (path_length_reg),
        .out_valid   (kin_valid),
        .out_kin     (kin_res),
        .out_dist    (kin_dist)
    );

    lsrp_place u_place (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (kin_valid),
        .in_kin         (kin_res),
        .in_dist        (kin_dist),
        .start_x        (start_x_reg),
        .start_y        (start_y_reg),
        .heading_cosine (heading_cosine_reg),
        .heading_sine   (heading_sine_reg),
        .out_valid      (out_valid),
        .out_kin        (out_kin),
        .pos_x          (pos_x),
        .pos_y          (pos_y)
    );

    assign heading_out = heading_angle_reg;
    assign speed_out   = out_kin.speed;
    assign time_stamp  = out_kin.t;
    assign reached_end = out_kin.reached;
    assign ramping     = out_kin.ramping;

endmodule
